// ===== hw/rtl/ucer_pkg.sv =====
// Package for the endpoint-0 control responder: item, result and state types,
// action and command codes, request codes and the descriptor table.
// No dependencies; every RTL file of the block uses it by scoped names.
`default_nettype none

package ucer_pkg;

  // Largest packet on endpoint 0 and the width of a chunk byte count.
  localparam int unsigned MAX_PACKET  = 64;
  localparam int unsigned CNT_W       = $clog2(MAX_PACKET + 1);
  localparam int unsigned MAX_RESULTS = 3;
  localparam int unsigned RCNT_W      = $clog2(MAX_RESULTS + 1);

  // Descriptor table.
  localparam int unsigned NUM_DESC = 6;
  localparam logic [2:0]  NO_DESC  = 3'd7;

  localparam logic [15:0] DESC_VALUE [NUM_DESC] = '{
    16'h0100, 16'h0200, 16'h0300, 16'h0301, 16'h0302, 16'h0600
  };
  localparam logic [15:0] DESC_INDEX [NUM_DESC] = '{
    16'h0000, 16'h0000, 16'h0000, 16'h0409, 16'h0409, 16'h0000
  };
  localparam logic [7:0] DESC_LEN [NUM_DESC] = '{
    8'd18, 8'd32, 8'd4, 8'(2 + 15 * 2), 8'(2 + 15 * 2), 8'd10
  };

  // Standard request codes and the vendor request type.
  localparam logic [7:0] REQ_GET_STATUS     = 8'h00;
  localparam logic [7:0] REQ_SET_ADDRESS    = 8'h05;
  localparam logic [7:0] REQ_GET_DESCRIPTOR = 8'h06;
  localparam logic [7:0] REQ_SET_CONFIG     = 8'h09;
  localparam logic [1:0] TYPE_VENDOR        = 2'd2;

  typedef enum logic [1:0] {
    CMD_BUS_RESET = 2'd0,
    CMD_SETUP     = 2'd1,
    CMD_IN        = 2'd2,
    CMD_OUT       = 2'd3
  } ucer_cmd_e;

  typedef enum logic [2:0] {
    ACT_NONE      = 3'd0,
    ACT_RELEASE   = 3'd1,
    ACT_TRANSMIT  = 3'd2,
    ACT_STALL     = 3'd3,
    ACT_SET_ADDR  = 3'd4,
    ACT_BUS_RESET = 3'd5
  } ucer_action_e;

  // One input beat.
  typedef struct packed {
    logic [1:0]  command;
    logic        bank_odd;
    logic [7:0]  setup_type;
    logic [7:0]  request;
    logic [15:0] setup_value;
    logic [15:0] setup_index;
    logic [15:0] setup_length;
  } ucer_item_t;

  // One result beat.
  typedef struct packed {
    ucer_action_e     action;
    logic             bank;
    logic             data_toggle;
    logic [2:0]       descriptor_sel;
    logic [7:0]       byte_offset;
    logic [CNT_W-1:0] byte_count;
    logic [6:0]       device_address;
    logic             last;
  } ucer_result_t;

  localparam ucer_result_t RESULT_NONE = '{
    action: ACT_NONE, bank: 1'b0, data_toggle: 1'b0, descriptor_sel: NO_DESC,
    byte_offset: 8'd0, byte_count: '0, device_address: 7'd0, last: 1'b0
  };

  // Endpoint state kept between beats.
  typedef struct packed {
    logic       odd_bank;
    logic       toggle_bit;
    logic       pending_valid;
    logic [2:0] pending_descriptor;
    logic [7:0] pending_offset;
    logic [7:0] pending_remaining;
    logic [7:0] saved_request;
    logic [6:0] saved_address;
  } ucer_state_t;

  localparam ucer_state_t STATE_RESET = '{
    odd_bank: 1'b0, toggle_bit: 1'b0, pending_valid: 1'b0,
    pending_descriptor: NO_DESC, pending_offset: 8'd0, pending_remaining: 8'd0,
    saved_request: 8'd0, saved_address: 7'd0
  };

  // Status of the result queue as seen by the input side.
  typedef struct packed {
    logic head_valid;
    logic can_load;
  } ucer_q_status_t;

  // Result of a descriptor table search.
  typedef struct packed {
    logic       hit;
    logic [2:0] sel;
    logic [7:0] len;
  } ucer_lookup_t;

  // First table entry whose wValue and wIndex both match.
  function automatic ucer_lookup_t desc_lookup(input logic [15:0] value,
                                               input logic [15:0] index);
    ucer_lookup_t r;
    r = '{hit: 1'b0, sel: NO_DESC, len: 8'd0};
    for (int i = NUM_DESC - 1; i >= 0; i--) begin
      if (DESC_VALUE[i] == value && DESC_INDEX[i] == index) begin
        r.hit = 1'b1;
        r.sel = 3'(i);
        r.len = DESC_LEN[i];
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/ucer_decode.sv =====
// Combinational response logic: turns one registered beat and the endpoint
// state into up to three results and the next state. Uses ucer_pkg.
`default_nettype none

module ucer_decode (
  input  var ucer_pkg::ucer_item_t   item_i,
  input  var ucer_pkg::ucer_state_t  state_i,
  output ucer_pkg::ucer_result_t     res_o [ucer_pkg::MAX_RESULTS],
  output logic [ucer_pkg::RCNT_W-1:0] res_cnt_o,
  output ucer_pkg::ucer_state_t      state_o
);

  localparam logic [7:0] MP8 = 8'(ucer_pkg::MAX_PACKET);

  ucer_pkg::ucer_cmd_e    cmd;
  ucer_pkg::ucer_lookup_t lk;
  logic       vendor;
  logic [7:0] len8;
  logic [7:0] size1;
  logic [7:0] rem1;
  logic [7:0] size2;
  logic [7:0] rem2;
  logic       done1;
  logic       done2;
  logic [7:0] in_size;
  logic [7:0] in_rem;

  assign cmd    = ucer_pkg::ucer_cmd_e'(item_i.command);
  assign vendor = (item_i.setup_type[6:5] == ucer_pkg::TYPE_VENDOR);
  assign lk     = ucer_pkg::desc_lookup(item_i.setup_value, item_i.setup_index);

  // GET_DESCRIPTOR: length clipped to wLength, then two chunks at most.
  assign len8  = ({8'd0, lk.len} > item_i.setup_length) ? item_i.setup_length[7:0] : lk.len;
  assign size1 = (len8 > MP8) ? MP8 : len8;
  assign rem1  = len8 - size1;
  assign done1 = (rem1 == 8'd0) && (size1 < MP8);
  assign size2 = (rem1 > MP8) ? MP8 : rem1;
  assign rem2  = rem1 - size2;
  assign done2 = (rem2 == 8'd0) && (size2 < MP8);

  // IN token: next chunk of the held transfer.
  assign in_size = (state_i.pending_remaining > MP8) ? MP8 : state_i.pending_remaining;
  assign in_rem  = state_i.pending_remaining - in_size;

  // Result list and state update.
  always_comb begin
    ucer_pkg::ucer_result_t r [ucer_pkg::MAX_RESULTS];
    logic [ucer_pkg::RCNT_W-1:0] n;
    ucer_pkg::ucer_state_t s;
    for (int i = 0; i < ucer_pkg::MAX_RESULTS; i++) begin
      r[i] = ucer_pkg::RESULT_NONE;
    end
    n = '0;
    s = state_i;
    unique case (cmd)
      ucer_pkg::CMD_BUS_RESET: begin
        s = ucer_pkg::STATE_RESET;
        r[0].action = ucer_pkg::ACT_BUS_RESET;
        n = 2'd1;
      end
      ucer_pkg::CMD_SETUP: begin
        r[0].action      = ucer_pkg::ACT_RELEASE;
        r[0].bank        = item_i.bank_odd;
        r[0].data_toggle = 1'b1;
        n = 2'd1;
        s.pending_valid      = 1'b0;
        s.pending_descriptor = ucer_pkg::NO_DESC;
        s.pending_offset     = 8'd0;
        s.pending_remaining  = 8'd0;
        s.toggle_bit         = 1'b1;
        s.saved_request      = item_i.request;
        s.saved_address      = item_i.setup_value[6:0];
        if (!vendor) begin
          if (item_i.request == ucer_pkg::REQ_SET_ADDRESS ||
              item_i.request == ucer_pkg::REQ_SET_CONFIG ||
              item_i.request == ucer_pkg::REQ_GET_STATUS) begin
            // Zero-length status packet.
            r[1].action      = ucer_pkg::ACT_TRANSMIT;
            r[1].bank        = state_i.odd_bank;
            r[1].data_toggle = 1'b1;
            s.odd_bank   = ~state_i.odd_bank;
            s.toggle_bit = 1'b0;
            n = 2'd2;
          end else if (item_i.request == ucer_pkg::REQ_GET_DESCRIPTOR && lk.hit) begin
            r[1].action         = ucer_pkg::ACT_TRANSMIT;
            r[1].bank           = state_i.odd_bank;
            r[1].data_toggle    = 1'b1;
            r[1].descriptor_sel = lk.sel;
            r[1].byte_offset    = 8'd0;
            r[1].byte_count     = ucer_pkg::CNT_W'(size1);
            if (done1) begin
              s.odd_bank   = ~state_i.odd_bank;
              s.toggle_bit = 1'b0;
              n = 2'd2;
            end else begin
              r[2].action         = ucer_pkg::ACT_TRANSMIT;
              r[2].bank           = ~state_i.odd_bank;
              r[2].data_toggle    = 1'b0;
              r[2].descriptor_sel = lk.sel;
              r[2].byte_offset    = size1;
              r[2].byte_count     = ucer_pkg::CNT_W'(size2);
              s.toggle_bit = 1'b1;
              n = 2'd3;
              if (!done2) begin
                s.pending_valid      = 1'b1;
                s.pending_descriptor = lk.sel;
                s.pending_offset     = size1 + size2;
                s.pending_remaining  = rem2;
              end
            end
          end else begin
            // Unknown request or missing descriptor.
            r[1].action = ucer_pkg::ACT_STALL;
            n = 2'd2;
          end
        end
      end
      ucer_pkg::CMD_IN: begin
        if (state_i.pending_valid) begin
          r[0].action         = ucer_pkg::ACT_TRANSMIT;
          r[0].bank           = state_i.odd_bank;
          r[0].data_toggle    = state_i.toggle_bit;
          r[0].descriptor_sel = state_i.pending_descriptor;
          r[0].byte_offset    = state_i.pending_offset;
          r[0].byte_count     = ucer_pkg::CNT_W'(in_size);
          s.odd_bank          = ~state_i.odd_bank;
          s.toggle_bit        = ~state_i.toggle_bit;
          s.pending_offset    = state_i.pending_offset + in_size;
          s.pending_remaining = in_rem;
          if (in_rem == 8'd0 && in_size < MP8) begin
            s.pending_valid      = 1'b0;
            s.pending_descriptor = ucer_pkg::NO_DESC;
            s.pending_offset     = 8'd0;
            s.pending_remaining  = 8'd0;
          end
          n = 2'd1;
        end
        // A saved SET_ADDRESS takes effect on every IN until the next SETUP or bus reset.
        if (state_i.saved_request == ucer_pkg::REQ_SET_ADDRESS) begin
          if (state_i.pending_valid) begin
            r[1].action         = ucer_pkg::ACT_SET_ADDR;
            r[1].device_address = state_i.saved_address;
          end else begin
            r[0].action         = ucer_pkg::ACT_SET_ADDR;
            r[0].device_address = state_i.saved_address;
          end
          n = n + 2'd1;
        end
      end
      ucer_pkg::CMD_OUT: begin
        r[0].action      = ucer_pkg::ACT_RELEASE;
        r[0].bank        = item_i.bank_odd;
        r[0].data_toggle = 1'b1;
        n = 2'd1;
      end
      default: begin
        n = '0;
      end
    endcase

    // Mark the final result of this beat.
    unique case (n)
      2'd1:    r[0].last = 1'b1;
      2'd2:    r[1].last = 1'b1;
      2'd3:    r[2].last = 1'b1;
      default: r[0].last = 1'b0;
    endcase

    res_o     = r;
    res_cnt_o = n;
    state_o   = s;
  end

endmodule

`default_nettype wire

// ===== hw/rtl/ucer_result_queue.sv =====
// Three-entry result queue: loaded with all results of one beat at once,
// drained one result per output beat from the head. Uses ucer_pkg.
`default_nettype none

module ucer_result_queue (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           load_i,
  input  var ucer_pkg::ucer_result_t     load_res_i [ucer_pkg::MAX_RESULTS],
  input  logic [ucer_pkg::RCNT_W-1:0]    load_cnt_i,
  input  logic                           out_stall_i,
  output ucer_pkg::ucer_result_t         head_o,
  output ucer_pkg::ucer_q_status_t       status_o
);

  ucer_pkg::ucer_result_t      slots_q [ucer_pkg::MAX_RESULTS];
  logic [ucer_pkg::RCNT_W-1:0] cnt_q;
  logic                        pop;

  // A new set may load when the queue is empty or its last entry leaves now.
  assign pop                 = (cnt_q != '0) && !out_stall_i;
  assign status_o.head_valid = (cnt_q != '0);
  assign status_o.can_load   = (cnt_q == '0) || ((cnt_q == 2'd1) && pop);
  assign head_o              = slots_q[0];

  // Occupancy count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (load_i) begin
      cnt_q <= load_cnt_i;
    end else if (pop) begin
      cnt_q <= cnt_q - 2'd1;
    end
  end

  // Result slots shift toward the head on each output beat.
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      slots_q <= load_res_i;
    end else if (pop) begin
      for (int i = 0; i < ucer_pkg::MAX_RESULTS - 1; i++) begin
        slots_q[i] <= slots_q[i+1];
      end
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/usb_control_endpoint_responder.sv =====
// The first result of a beat passes the input register and the result queue before it is offered.
// Throughput: one input beat per cycle for beats with at most one result while the output is
// not stalled; after a beat with several results, the next beat waits in the input register
// until the result queue has drained them.
// Reset: rst_ni clears the endpoint state, the input register and the result queue.
// Top level: input register, endpoint state, ucer_decode and ucer_result_queue.
`default_nettype none

module usb_control_endpoint_responder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  command_i,
  input  logic        bank_odd_i,
  input  logic [7:0]  setup_type_i,
  input  logic [7:0]  request_i,
  input  logic [15:0] setup_value_i,
  input  logic [15:0] setup_index_i,
  input  logic [15:0] setup_length_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  action_o,
  output logic        bank_o,
  output logic        data_toggle_o,
  output logic [2:0]  descriptor_sel_o,
  output logic [7:0]  byte_offset_o,
  output logic [ucer_pkg::CNT_W-1:0] byte_count_o,
  output logic [6:0]  device_address_o,
  output logic        last_o
);

  ucer_pkg::ucer_item_t        item_q;
  logic                        item_valid_q;
  ucer_pkg::ucer_state_t       state_q;
  ucer_pkg::ucer_state_t       state_d;
  ucer_pkg::ucer_result_t      res_d [ucer_pkg::MAX_RESULTS];
  logic [ucer_pkg::RCNT_W-1:0] res_cnt_d;
  ucer_pkg::ucer_result_t      head;
  ucer_pkg::ucer_q_status_t    q_status;
  logic                        load;
  logic                        in_accept;

  // Input handshake: the held beat is processed once the queue can take its results.
  assign load       = item_valid_q && q_status.can_load;
  assign in_stall_o = item_valid_q && !q_status.can_load;
  assign in_accept  = in_valid_i && !in_stall_o;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
    end else if (in_accept) begin
      item_valid_q <= 1'b1;
    end else if (load) begin
      item_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      item_q <= '{command: command_i, bank_odd: bank_odd_i, setup_type: setup_type_i,
                  request: request_i, setup_value: setup_value_i,
                  setup_index: setup_index_i, setup_length: setup_length_i};
    end
  end

  // Endpoint state advances when a beat is processed.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ucer_pkg::STATE_RESET;
    end else if (load) begin
      state_q <= state_d;
    end
  end

  ucer_decode u_decode (
    .item_i    (item_q),
    .state_i   (state_q),
    .res_o     (res_d),
    .res_cnt_o (res_cnt_d),
    .state_o   (state_d)
  );

  ucer_result_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (load),
    .load_res_i  (res_d),
    .load_cnt_i  (res_cnt_d),
    .out_stall_i (out_stall_i),
    .head_o      (head),
    .status_o    (q_status)
  );

  // Output beat from the queue head.
  assign out_valid_o      = q_status.head_valid;
  assign action_o         = head.action;
  assign bank_o           = head.bank;
  assign data_toggle_o    = head.data_toggle;
  assign descriptor_sel_o = head.descriptor_sel;
  assign byte_offset_o    = head.byte_offset;
  assign byte_count_o     = head.byte_count;
  assign device_address_o = head.device_address;
  assign last_o           = head.last;

  // A chunk never exceeds the endpoint's packet size.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> byte_count_o <= ucer_pkg::CNT_W'(ucer_pkg::MAX_PACKET))
    else $error("chunk byte count above packet size");

  // A held transfer always names a table entry.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.pending_valid |-> state_q.pending_descriptor != ucer_pkg::NO_DESC)
    else $error("pending transfer without descriptor");

  // A beat waiting for the queue stays in the input register unchanged.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_valid_q && !load |=> item_valid_q && $stable(item_q))
    else $error("input beat lost while waiting for the queue");

  // Receive banks are always released as DATA1.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && action_o == ucer_pkg::ACT_RELEASE |-> data_toggle_o)
    else $error("bank release without DATA1");

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
// Self-checking testbench for the endpoint-0 control responder: a directed table of
// token beats, then random control transfers, checked against a predictor of the block.
// Depends on ucer_pkg and usb_control_endpoint_responder only.
`timescale 1ns / 100ps

module tb_top;
  import ucer_pkg::*;

  localparam int DIRECTED_BEATS = 25;
  localparam int RANDOM_BEATS   = 155;
  localparam int HOLD_CYCLES    = 80;

  // One row of stimulus: a beat, and where it is obvious, the results it must cause.
  typedef struct {
    ucer_item_t   it;
    bit           known;
    int           n;
    ucer_result_t r0;
    ucer_result_t r1;
  } beat_plan_t;

  logic         clk_i       = 1'b0;
  logic         rst_ni      = 1'b0;
  logic         in_valid_i  = 1'b0;
  logic         out_stall_i = 1'b0;
  ucer_item_t   drv         = '0;
  logic         in_stall_o;
  logic         out_valid_o;
  logic [2:0]   action_o;
  logic         bank_o;
  logic         data_toggle_o;
  logic [2:0]   descriptor_sel_o;
  logic [7:0]   byte_offset_o;
  logic [CNT_W-1:0] byte_count_o;
  logic [6:0]   device_address_o;
  logic         last_o;

  ucer_result_t awaited_results[$];
  ucer_result_t beat_results[$];
  beat_plan_t   directed_plan[$];
  int           fault_count   = 0;
  int           beats_sent    = 0;
  int           burst_left    = 0;
  bit           calm          = 1'b0;
  bit           hold_request  = 1'b0;

  // Predicted endpoint state.
  logic       ep_odd_bank;
  logic       ep_toggle;
  logic       ep_pend_valid;
  logic [2:0] ep_pend_desc;
  logic [7:0] ep_pend_off;
  logic [7:0] ep_pend_rem;
  logic [7:0] ep_saved_req;
  logic [6:0] ep_saved_addr;

  // Descriptor table: wValue, wIndex and length of each entry.
  logic [15:0] desc_value [6] = '{16'h0100, 16'h0200, 16'h0300, 16'h0301, 16'h0302, 16'h0600};
  logic [15:0] desc_index [6] = '{16'h0000, 16'h0000, 16'h0000, 16'h0409, 16'h0409, 16'h0000};
  int          desc_len   [6] = '{18, 32, 4, 32, 32, 10};

  usb_control_endpoint_responder dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .command_i        (drv.command),
    .bank_odd_i       (drv.bank_odd),
    .setup_type_i     (drv.setup_type),
    .request_i        (drv.request),
    .setup_value_i    (drv.setup_value),
    .setup_index_i    (drv.setup_index),
    .setup_length_i   (drv.setup_length),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .action_o         (action_o),
    .bank_o           (bank_o),
    .data_toggle_o    (data_toggle_o),
    .descriptor_sel_o (descriptor_sel_o),
    .byte_offset_o    (byte_offset_o),
    .byte_count_o     (byte_count_o),
    .device_address_o (device_address_o),
    .last_o           (last_o)
  );

  // Clock, 10 ns period.
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Hard limit on the run.
  initial begin
    #3_000_000;
    $display("FAIL usb_control_endpoint_responder");
    $finish;
  end

  function automatic ucer_item_t beat(input logic [1:0] cmd, input logic bank,
                                      input logic [7:0] rtype, input logic [7:0] req,
                                      input logic [15:0] val, input logic [15:0] idx,
                                      input logic [15:0] len);
    return '{command: cmd, bank_odd: bank, setup_type: rtype, request: req,
             setup_value: val, setup_index: idx, setup_length: len};
  endfunction

  // A result with no data attached: release, stall, set address or bus reset.
  function automatic ucer_result_t plain(input ucer_action_e act, input logic bank,
                                         input logic tog, input logic [6:0] addr,
                                         input logic last);
    return '{action: act, bank: bank, data_toggle: tog, descriptor_sel: NO_DESC,
             byte_offset: 8'd0, byte_count: '0, device_address: addr, last: last};
  endfunction

  function automatic beat_plan_t plan_known(input ucer_item_t it, input int n,
                                            input ucer_result_t r0, input ucer_result_t r1);
    return '{it: it, known: 1'b1, n: n, r0: r0, r1: r1};
  endfunction

  function automatic beat_plan_t plan_predicted(input ucer_item_t it);
    return '{it: it, known: 1'b0, n: 0, r0: RESULT_NONE, r1: RESULT_NONE};
  endfunction

  function automatic ucer_item_t random_token(input logic [1:0] cmd);
    return beat(cmd, 1'($urandom), 8'($urandom), 8'($urandom), 16'($urandom),
                16'($urandom), 16'($urandom));
  endfunction

  // Gap length for either side: mostly none, sometimes short, now and then long.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic string show(input ucer_result_t r);
    return $sformatf("act %0d bank %0d tog %0d sel %0d off %0d cnt %0d addr %0d last %0d",
                     r.action, r.bank, r.data_toggle, r.descriptor_sel, r.byte_offset,
                     r.byte_count, r.device_address, r.last);
  endfunction

  function automatic void note_fault(input string msg);
    fault_count++;
    if (fault_count <= 10) $display("%t %s", $realtime, msg);
  endfunction

  // Predictor: endpoint state and the results of one beat.
  function automatic void clear_pending();
    ep_pend_valid = 1'b0;
    ep_pend_desc  = NO_DESC;
    ep_pend_off   = 8'd0;
    ep_pend_rem   = 8'd0;
  endfunction

  function automatic void reset_endpoint();
    ep_odd_bank   = 1'b0;
    ep_toggle     = 1'b0;
    ep_saved_req  = 8'd0;
    ep_saved_addr = 7'd0;
    clear_pending();
  endfunction

  function automatic void push_result(input ucer_action_e act, input logic bank,
                                      input logic tog, input logic [2:0] sel,
                                      input logic [7:0] off, input logic [CNT_W-1:0] cnt,
                                      input logic [6:0] addr);
    beat_results.push_back('{action: act, bank: bank, data_toggle: tog, descriptor_sel: sel,
                             byte_offset: off, byte_count: cnt, device_address: addr,
                             last: 1'b0});
  endfunction

  // A transmit uses the current bank and toggle, then flips both.
  function automatic void transmit_chunk(input logic [2:0] sel, input logic [7:0] off,
                                         input logic [CNT_W-1:0] cnt);
    push_result(ACT_TRANSMIT, ep_odd_bank, ep_toggle, sel, off, cnt, 7'd0);
    ep_odd_bank = ~ep_odd_bank;
    ep_toggle   = ~ep_toggle;
  endfunction

  function automatic void ep0_respond(input ucer_item_t it);
    int  sel, len, size, off, k;
    bit  done;
    beat_results.delete();
    case (it.command)
      CMD_BUS_RESET: begin
        reset_endpoint();
        push_result(ACT_BUS_RESET, 1'b0, 1'b0, NO_DESC, 8'd0, '0, 7'd0);
      end
      CMD_SETUP: begin
        push_result(ACT_RELEASE, it.bank_odd, 1'b1, NO_DESC, 8'd0, '0, 7'd0);
        clear_pending();
        ep_toggle     = 1'b1;
        ep_saved_req  = it.request;
        ep_saved_addr = it.setup_value[6:0];
        // Vendor requests are only acknowledged by the bank release.
        if (it.setup_type[6:5] != TYPE_VENDOR) begin
          if (it.request == REQ_SET_ADDRESS || it.request == REQ_SET_CONFIG ||
              it.request == REQ_GET_STATUS) begin
            transmit_chunk(NO_DESC, 8'd0, '0);
          end else if (it.request == REQ_GET_DESCRIPTOR) begin
            sel = -1;
            for (int i = 0; i < 6; i++) begin
              if (sel < 0 && desc_value[i] == it.setup_value &&
                  desc_index[i] == it.setup_index) sel = i;
            end
            if (sel < 0) begin
              push_result(ACT_STALL, 1'b0, 1'b0, NO_DESC, 8'd0, '0, 7'd0);
            end else begin
              len = desc_len[sel];
              if (len > int'(it.setup_length)) len = it.setup_length;
              off  = 0;
              done = 1'b0;
              for (k = 0; k < 2 && !done; k++) begin
                size = (len > int'(MAX_PACKET)) ? int'(MAX_PACKET) : len;
                transmit_chunk(3'(sel), 8'(off), CNT_W'(size));
                off += size;
                len -= size;
                if (len == 0 && size < int'(MAX_PACKET)) done = 1'b1;
              end
              // Whatever did not fit in two chunks waits for IN tokens.
              if (!done) begin
                ep_pend_valid = 1'b1;
                ep_pend_desc  = 3'(sel);
                ep_pend_off   = 8'(off);
                ep_pend_rem   = 8'(len);
              end
            end
          end else begin
            push_result(ACT_STALL, 1'b0, 1'b0, NO_DESC, 8'd0, '0, 7'd0);
          end
        end
      end
      CMD_IN: begin
        if (ep_pend_valid) begin
          size = (int'(ep_pend_rem) > int'(MAX_PACKET)) ? int'(MAX_PACKET) : ep_pend_rem;
          transmit_chunk(ep_pend_desc, ep_pend_off, CNT_W'(size));
          ep_pend_off = ep_pend_off + 8'(size);
          ep_pend_rem = ep_pend_rem - 8'(size);
          // A full chunk is always followed by one more, possibly empty.
          if (!(ep_pend_rem > 0 || size == int'(MAX_PACKET))) clear_pending();
        end
        if (ep_saved_req == REQ_SET_ADDRESS) begin
          push_result(ACT_SET_ADDR, 1'b0, 1'b0, NO_DESC, 8'd0, '0, ep_saved_addr);
        end
      end
      default: begin
        push_result(ACT_RELEASE, it.bank_odd, 1'b1, NO_DESC, 8'd0, '0, 7'd0);
      end
    endcase
    if (beat_results.size() > 0) beat_results[beat_results.size() - 1].last = 1'b1;
  endfunction

  // Offers one beat from a falling edge, records its results on acceptance, and
  // returns at a falling edge after an optional gap.
  task automatic send_beat(input beat_plan_t p);
    int gap;
    drv        = p.it;
    in_valid_i = 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    ep0_respond(p.it);
    if (p.known) begin
      if (p.n >= 1) awaited_results.push_back(p.r0);
      if (p.n >= 2) awaited_results.push_back(p.r1);
    end else begin
      foreach (beat_results[i]) awaited_results.push_back(beat_results[i]);
    end
    beats_sent++;
    @(negedge clk_i);
    gap = (burst_left > 0 || calm) ? 0 : gap_len();
    if (burst_left > 0) burst_left--;
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
  endtask

  // One control transfer: SETUP, up to three IN tokens, usually the OUT status stage, then maybe an IN.
  task automatic run_transfer();
    ucer_item_t s;
    int         kind, j;
    logic [7:0] rtype;
    rtype = $urandom_range(0, 1) ? 8'h80 : 8'($urandom);
    if (rtype[6:5] == TYPE_VENDOR) rtype[5] = 1'b1;
    s = beat(CMD_SETUP, 1'($urandom), rtype, 8'($urandom), 16'($urandom),
             16'($urandom), 16'($urandom));
    kind = $urandom_range(0, 9);
    case (kind)
      0, 1, 2, 3: begin
        j = $urandom_range(0, 5);
        s.request     = REQ_GET_DESCRIPTOR;
        s.setup_value = desc_value[j];
        s.setup_index = desc_index[j];
        if ($urandom_range(0, 3) != 0) s.setup_length = 16'($urandom_range(0, 40));
      end
      4: s.request = REQ_GET_DESCRIPTOR;
      5: s.request = REQ_SET_ADDRESS;
      6: s.request = $urandom_range(0, 1) ? REQ_SET_CONFIG : REQ_GET_STATUS;
      7: s.setup_type[6:5] = TYPE_VENDOR;
      default: ;
    endcase
    send_beat(plan_predicted(s));
    repeat ($urandom_range(0, 3)) send_beat(plan_predicted(random_token(CMD_IN)));
    if ($urandom_range(0, 4) != 0) send_beat(plan_predicted(random_token(CMD_OUT)));
    if ($urandom_range(0, 1) != 0) send_beat(plan_predicted(random_token(CMD_IN)));
  endtask

  // Receiver: random stalls, a long hold-off on request, none while calm.
  initial begin
    int stall_left;
    stall_left = 0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_request) begin
        stall_left   = HOLD_CYCLES;
        hold_request = 1'b0;
      end else if (stall_left == 0 && !calm) begin
        stall_left = gap_len();
      end
      out_stall_i = (stall_left > 0);
      if (stall_left > 0) stall_left--;
    end
  end

  // Result checker: every accepted beat against the oldest expectation.
  always @(posedge clk_i) begin
    ucer_result_t seen, want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      seen = '{action: ucer_action_e'(action_o), bank: bank_o, data_toggle: data_toggle_o,
               descriptor_sel: descriptor_sel_o, byte_offset: byte_offset_o,
               byte_count: byte_count_o, device_address: device_address_o, last: last_o};
      if (awaited_results.size() == 0) begin
        note_fault({"unexpected result beat: ", show(seen)});
      end else begin
        want = awaited_results.pop_front();
        if (seen !== want) note_fault({"result mismatch, expected ", show(want),
                                       " got ", show(seen)});
      end
    end
  end

  // Stimulus: reset, directed table, random transfers, then drain.
  initial begin
    bit hold_done, drain_done;
    hold_done  = 1'b0;
    drain_done = 1'b0;
    reset_endpoint();

    // Directed table; a row with a count lists its results, the rest are predicted.
    directed_plan.push_back(plan_known(beat(CMD_IN, 1'b1, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF,
                                            16'hFFFF), 0, RESULT_NONE, RESULT_NONE));
    directed_plan.push_back(plan_known(beat(CMD_BUS_RESET, 1'b1, 8'hFF, 8'hFF, 16'hFFFF,
                                            16'hFFFF, 16'hFFFF), 1,
                                       plain(ACT_BUS_RESET, 1'b0, 1'b0, 7'd0, 1'b1),
                                       RESULT_NONE));
    directed_plan.push_back(plan_known(beat(CMD_OUT, 1'b1, 8'h00, 8'h00, 16'h0000, 16'h0000,
                                            16'h0000), 1,
                                       plain(ACT_RELEASE, 1'b1, 1'b1, 7'd0, 1'b1),
                                       RESULT_NONE));
    directed_plan.push_back(plan_known(beat(CMD_OUT, 1'b0, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF,
                                            16'hFFFF), 1,
                                       plain(ACT_RELEASE, 1'b0, 1'b1, 7'd0, 1'b1),
                                       RESULT_NONE));
    directed_plan.push_back(plan_predicted(beat(CMD_SETUP, 1'b0, 8'h80, REQ_GET_STATUS,
                                                16'h0000, 16'h0000, 16'h0002)));
    directed_plan.push_back(plan_predicted(beat(CMD_SETUP, 1'b1, 8'h80, REQ_GET_DESCRIPTOR,
                                                16'h0100, 16'h0000, 16'hFFFF)));
    directed_plan.push_back(plan_predicted(random_token(CMD_IN)));
    directed_plan.push_back(plan_predicted(beat(CMD_SETUP, 1'b0, 8'h80, REQ_GET_DESCRIPTOR,
                                                16'h0200, 16'h0000, 16'd9)));
    directed_plan.push_back(plan_predicted(beat(CMD_SETUP, 1'b1, 8'h80, REQ_GET_DESCRIPTOR,
                                                16'h0300, 16'h0000, 16'd0)));
    directed_plan.push_back(plan_predicted(beat(CMD_SETUP, 1'b0, 8'h80, REQ_GET_DESCRIPTOR,
                                                16'h0301, 16'h0409, 16'd255)));
    directed_plan.push_back(plan_predicted(beat(CMD_SETUP, 1'b1, 8'h80, REQ_GET_DESCRIPTOR,
                                                16'h0302, 16'h0409, 16'd32)));
    directed_plan.push_back(plan_predicted(beat(CMD_SETUP, 1'b0, 8'h80, REQ_GET_DESCRIPTOR,
                                                16'h0600, 16'h0000, 16'd11)));
    // Missing descriptor and unknown request: release, then stall.
    directed_plan.push_back(plan_known(beat(CMD_SETUP, 1'b0, 8'h80, REQ_GET_DESCRIPTOR,
                                            16'h0301, 16'h0000, 16'd64), 2,
                                       plain(ACT_RELEASE, 1'b0, 1'b1, 7'd0, 1'b0),
                                       plain(ACT_STALL, 1'b0, 1'b0, 7'd0, 1'b1)));
    directed_plan.push_back(plan_known(beat(CMD_SETUP, 1'b1, 8'h00, 8'hFF, 16'h0000,
                                            16'h0000, 16'h0000), 2,
                                       plain(ACT_RELEASE, 1'b1, 1'b1, 7'd0, 1'b0),
                                       plain(ACT_STALL, 1'b0, 1'b0, 7'd0, 1'b1)));
    // Vendor requests only release the bank, but a saved SET_ADDRESS still acts on IN.
    directed_plan.push_back(plan_known(beat(CMD_SETUP, 1'b0, 8'h40, REQ_GET_DESCRIPTOR,
                                            16'h0100, 16'h0000, 16'd18), 1,
                                       plain(ACT_RELEASE, 1'b0, 1'b1, 7'd0, 1'b1),
                                       RESULT_NONE));
    directed_plan.push_back(plan_known(beat(CMD_SETUP, 1'b1, 8'hC0, REQ_SET_ADDRESS,
                                            16'h007F, 16'h0000, 16'h0000), 1,
                                       plain(ACT_RELEASE, 1'b1, 1'b1, 7'd0, 1'b1),
                                       RESULT_NONE));
    directed_plan.push_back(plan_known(random_token(CMD_IN), 1,
                                       plain(ACT_SET_ADDR, 1'b0, 1'b0, 7'h7F, 1'b1),
                                       RESULT_NONE));
    directed_plan.push_back(plan_known(random_token(CMD_IN), 1,
                                       plain(ACT_SET_ADDR, 1'b0, 1'b0, 7'h7F, 1'b1),
                                       RESULT_NONE));
    directed_plan.push_back(plan_predicted(beat(CMD_SETUP, 1'b0, 8'h21, REQ_SET_CONFIG,
                                                16'h0001, 16'h0000, 16'h0000)));
    directed_plan.push_back(plan_predicted(beat(CMD_SETUP, 1'b0, 8'h00, REQ_SET_ADDRESS,
                                                16'hFFFF, 16'h0000, 16'h0000)));
    directed_plan.push_back(plan_known(random_token(CMD_IN), 1,
                                       plain(ACT_SET_ADDR, 1'b0, 1'b0, 7'h7F, 1'b1),
                                       RESULT_NONE));
    // Reserved request type is handled like a standard one.
    directed_plan.push_back(plan_predicted(beat(CMD_SETUP, 1'b1, 8'h60, REQ_SET_CONFIG,
                                                16'h0000, 16'h0000, 16'h0000)));
    directed_plan.push_back(plan_known(beat(CMD_SETUP, 1'b1, 8'hFF, 8'hFF, 16'hFFFF,
                                            16'hFFFF, 16'hFFFF), 2,
                                       plain(ACT_RELEASE, 1'b1, 1'b1, 7'd0, 1'b0),
                                       plain(ACT_STALL, 1'b0, 1'b0, 7'd0, 1'b1)));
    directed_plan.push_back(plan_known(random_token(CMD_BUS_RESET), 1,
                                       plain(ACT_BUS_RESET, 1'b0, 1'b0, 7'd0, 1'b1),
                                       RESULT_NONE));
    directed_plan.push_back(plan_known(random_token(CMD_IN), 0, RESULT_NONE, RESULT_NONE));

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (directed_plan[i]) send_beat(directed_plan[i]);

    // Random part: mostly well-formed transfers, the rest arbitrary beats.
    while (beats_sent < DIRECTED_BEATS + RANDOM_BEATS) begin
      if (!hold_done && beats_sent > DIRECTED_BEATS + 50) begin
        // Long receiver hold-off while the sender keeps offering back to back.
        hold_request = 1'b1;
        burst_left   = 30;
        hold_done    = 1'b1;
      end
      if (!drain_done && beats_sent > DIRECTED_BEATS + 120) begin
        in_valid_i = 1'b0;
        wait (awaited_results.size() == 0);
        @(negedge clk_i);
        drain_done = 1'b1;
      end
      if ($urandom_range(0, 39) == 0) calm = ~calm;
      if ($urandom_range(0, 3) != 0) run_transfer();
      else send_beat(plan_predicted(random_token(2'($urandom_range(0, 3)))));
    end

    in_valid_i = 1'b0;
    wait (awaited_results.size() == 0);
    repeat (10) @(posedge clk_i);
    if (fault_count == 0) begin
      $display("PASS usb_control_endpoint_responder");
    end else begin
      $display("FAIL usb_control_endpoint_responder");
    end
    $finish;
  end

endmodule
